>>> src/wrlp_pkg.sv
// shared types, character codes and constants of the waypoint reply line parser
package wrlp_pkg;

   // default sizes
   localparam int LINE_LIMIT_DEF  = 256;
   localparam int TOKQ_DEPTH_DEF  = 4;
   localparam int RSPQ_DEPTH_DEF  = 2;
   localparam logic [15:0] MAX_COUNT_RESET = 16'd500;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_W     = 8'h57;

   // line kinds on the result
   localparam logic [1:0] KIND_INVALID  = 2'd0;
   localparam logic [1:0] KIND_COUNT    = 2'd1;
   localparam logic [1:0] KIND_WAYPOINT = 2'd2;
   localparam logic [1:0] KIND_END      = 2'd3;

   // token passed from front to back
   typedef enum logic [1:0] {
      TOK_TYPE,
      TOK_FEED,
      TOK_EOL
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
   } token_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]         line_kind;
      logic               ack;
      logic signed [31:0] count_value;
      logic signed [31:0] lat_value;
      logic signed [31:0] lon_value;
      logic [15:0]        wp_index;
   } result_type;

endpackage

>>> src/waypoint_reply_line_parser_core.sv
// top level of the waypoint reply line parser: front, token queue, back, result queue
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+------------------------------
//  input    | req_rx_byte, push, full                | push && !full
//  result   | rsp_* fields, empty, pop               | pop && !empty
//  csr      | csr_wr_en, csr_wr_data (max_count)     | csr_wr_en
//
// one byte is accepted per cycle while the token queue is not full; the front classifies it
// in the cycle it arrives and the back consumes one token per cycle, when one is waiting,
// from a four-entry token queue. a line end passes through it to the two-entry result queue.
// full follows the token queue; a line end stalls the back only while the result
// queue is full. reset is synchronous, clears all line state and sets max_count to 500.
module waypoint_reply_line_parser_core #(
   parameter int LINE_LIMIT = wrlp_pkg::LINE_LIMIT_DEF,
   parameter int TOKQ_DEPTH = wrlp_pkg::TOKQ_DEPTH_DEF,
   parameter int RSPQ_DEPTH = wrlp_pkg::RSPQ_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               push,
   input  logic [7:0]         req_rx_byte,
   output logic               full,
   // result channel
   input  logic               pop,
   output logic               empty,
   output logic [1:0]         rsp_line_kind,
   output logic               rsp_ack,
   output logic signed [31:0] rsp_count_value,
   output logic signed [31:0] rsp_lat_value,
   output logic signed [31:0] rsp_lon_value,
   output logic [15:0]        rsp_wp_index,
   // configuration
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   localparam int TOK_W = $bits(wrlp_pkg::token_type);
   localparam int RSP_W = $bits(wrlp_pkg::result_type);

   logic                 tok_push, tok_full, tok_empty, tok_pop;
   wrlp_pkg::token_type  tok_wr, tok_rd;
   logic                 rsp_push, rsp_full;
   wrlp_pkg::result_type rsp_wr, rsp_rd;

   // byte classification
   wrlp_front #(
      .LINE_LIMIT(LINE_LIMIT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_push (push),
      .in_byte (req_rx_byte),
      .in_full (full),
      .tok_push(tok_push),
      .tok_data(tok_wr),
      .tok_full(tok_full)
   );

   // token queue
   wrlp_fifo #(
      .WIDTH(TOK_W),
      .DEPTH(TOKQ_DEPTH)
   ) u_tok_q (
      .clock  (clock),
      .reset  (reset),
      .push   (tok_push),
      .wr_data(tok_wr),
      .full   (tok_full),
      .pop    (tok_pop),
      .rd_data(tok_rd),
      .empty  (tok_empty)
   );

   // number parsing and result build
   wrlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .tok_data   (tok_rd),
      .tok_empty  (tok_empty),
      .tok_pop    (tok_pop),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_wr),
      .rsp_full   (rsp_full)
   );

   // result queue
   wrlp_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSPQ_DEPTH)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_wr),
      .full   (rsp_full),
      .pop    (pop),
      .rd_data(rsp_rd),
      .empty  (empty)
   );

   assign rsp_line_kind   = rsp_rd.line_kind;
   assign rsp_ack         = rsp_rd.ack;
   assign rsp_count_value = rsp_rd.count_value;
   assign rsp_lat_value   = rsp_rd.lat_value;
   assign rsp_lon_value   = rsp_rd.lon_value;
   assign rsp_wp_index    = rsp_rd.wp_index;

endmodule

>>> src/wrlp_fifo.sv
// small register queue used between front, back and the result port
module wrlp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/wrlp_front.sv
// front end: tracks the position in the line and turns bytes into tokens
module wrlp_front #(
   parameter int LINE_LIMIT = wrlp_pkg::LINE_LIMIT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_push,
   input  logic [7:0]          in_byte,
   output logic                in_full,
   output logic                tok_push,
   output wrlp_pkg::token_type tok_data,
   input  logic                tok_full
);

   localparam int POS_W = $clog2(LINE_LIMIT);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_LIMIT - 1);

   logic [POS_W-1:0] char_pos_ff, char_pos_in;
   logic             accept;
   logic             emit;
   wrlp_pkg::tok_kind_type kind;

   assign in_full = tok_full;
   assign accept  = in_push && !tok_full;

   // classify the byte against the line position
   always_comb begin
      char_pos_in = char_pos_ff;
      emit        = 1'b0;
      kind        = wrlp_pkg::TOK_FEED;
      if (in_byte == wrlp_pkg::CH_LF || in_byte == wrlp_pkg::CH_CR) begin
         emit        = 1'b1;
         kind        = wrlp_pkg::TOK_EOL;
         char_pos_in = '0;
      end else if (char_pos_ff == LAST_POS) begin
         // line full or cut by a nul: drop until line end
         emit = 1'b0;
      end else if (in_byte == wrlp_pkg::CH_NUL) begin
         char_pos_in = LAST_POS;
      end else if (char_pos_ff == '0) begin
         emit        = 1'b1;
         kind        = wrlp_pkg::TOK_TYPE;
         char_pos_in = char_pos_ff + 1'b1;
      end else begin
         // second character is skipped, the rest is parsed
         emit        = (char_pos_ff != POS_W'(1));
         char_pos_in = char_pos_ff + 1'b1;
      end
   end

   assign tok_push      = accept && emit;
   assign tok_data.kind = kind;
   assign tok_data.data = in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_pos_ff <= '0;
      end else if (accept) begin
         char_pos_ff <= char_pos_in;
      end
   end

endmodule

>>> src/wrlp_back.sv
// back end: accumulates numbers per token and builds one result per line end
module wrlp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  wrlp_pkg::token_type  tok_data,
   input  logic                 tok_empty,
   output logic                 tok_pop,
   output logic                 rsp_push,
   output wrlp_pkg::result_type rsp_data,
   input  logic                 rsp_full
);

   // count parser phases
   typedef enum logic [1:0] {
      PH_SKIP,
      PH_POS,
      PH_NEG,
      PH_DONE
   } phase_type;

   logic [15:0] max_count_ff;
   logic [7:0]  line_type_ff, line_type_in;
   logic [1:0]  word_num_ff, word_num_in;
   logic [31:0] acc_first_ff, acc_first_in;
   logic [31:0] acc_second_ff, acc_second_in;
   logic [1:0]  neg_flags_ff, neg_flags_in;
   logic [1:0]  stop_flags_ff, stop_flags_in;
   logic [31:0] count_acc_ff, count_acc_in;
   phase_type   count_phase_ff, count_phase_in;
   logic [15:0] next_index_ff, next_index_in;

   logic [7:0]  ch;
   logic        is_digit;
   logic        is_blank;
   logic [31:0] digit;
   logic        is_eol;
   logic [31:0] cnt_v, lat_v, lon_v;
   logic [31:0] word_acc, word_acc_next;

   // multiply by ten as two shifts and an add
   function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [31:0] d);
      mul10_add = (acc << 3) + (acc << 1) + d;
   endfunction

   assign ch       = tok_data.data;
   assign is_digit = (ch >= wrlp_pkg::CH_ZERO) && (ch <= wrlp_pkg::CH_NINE);
   assign is_blank = (ch == wrlp_pkg::CH_SPACE) || (ch == wrlp_pkg::CH_TAB) ||
                     (ch == wrlp_pkg::CH_VT) || (ch == wrlp_pkg::CH_FF);
   assign digit    = {24'b0, ch - wrlp_pkg::CH_ZERO};
   assign is_eol   = (tok_data.kind == wrlp_pkg::TOK_EOL);

   // a line end waits for room in the result queue
   assign tok_pop  = !tok_empty && !(is_eol && rsp_full);
   assign rsp_push = tok_pop && is_eol;

   assign word_acc      = (word_num_ff == 2'd0) ? acc_first_ff : acc_second_ff;
   assign word_acc_next = mul10_add(word_acc, digit);

   // signed values at line end
   assign cnt_v = (count_phase_ff == PH_NEG) ? (32'd0 - count_acc_ff) : count_acc_ff;
   assign lat_v = neg_flags_ff[0] ? (32'd0 - acc_first_ff) : acc_first_ff;
   assign lon_v = neg_flags_ff[1] ? (32'd0 - acc_second_ff) : acc_second_ff;

   // result formation
   always_comb begin
      rsp_data = '0;
      if (line_type_ff == wrlp_pkg::CH_N) begin
         rsp_data.line_kind   = wrlp_pkg::KIND_COUNT;
         rsp_data.count_value = cnt_v;
         rsp_data.ack         = cnt_v[31] || (cnt_v <= {16'b0, max_count_ff});
      end else if (line_type_ff == wrlp_pkg::CH_W) begin
         rsp_data.line_kind = wrlp_pkg::KIND_WAYPOINT;
         rsp_data.ack       = 1'b1;
         rsp_data.lat_value = lat_v;
         rsp_data.lon_value = lon_v;
         rsp_data.wp_index  = next_index_ff;
      end else if (line_type_ff == wrlp_pkg::CH_E) begin
         rsp_data.line_kind = wrlp_pkg::KIND_END;
         rsp_data.ack       = 1'b1;
      end
   end

   // line state update per token
   always_comb begin
      line_type_in   = line_type_ff;
      word_num_in    = word_num_ff;
      acc_first_in   = acc_first_ff;
      acc_second_in  = acc_second_ff;
      neg_flags_in   = neg_flags_ff;
      stop_flags_in  = stop_flags_ff;
      count_acc_in   = count_acc_ff;
      count_phase_in = count_phase_ff;
      next_index_in  = next_index_ff;
      unique case (tok_data.kind)
         wrlp_pkg::TOK_TYPE: begin
            line_type_in = ch;
         end
         wrlp_pkg::TOK_FEED: begin
            // count number: blanks, sign, digits
            unique case (count_phase_ff)
               PH_SKIP: begin
                  if (is_blank) begin
                     count_phase_in = PH_SKIP;
                  end else if (ch == wrlp_pkg::CH_PLUS) begin
                     count_phase_in = PH_POS;
                  end else if (ch == wrlp_pkg::CH_MINUS) begin
                     count_phase_in = PH_NEG;
                  end else if (is_digit) begin
                     count_phase_in = PH_POS;
                     count_acc_in   = mul10_add(count_acc_ff, digit);
                  end else begin
                     count_phase_in = PH_DONE;
                  end
               end
               PH_POS, PH_NEG: begin
                  if (is_digit) begin
                     count_acc_in = mul10_add(count_acc_ff, digit);
                  end else begin
                     count_phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
                  count_phase_in = PH_DONE;
               end
               default: begin
                  count_phase_in = count_phase_ff;
               end
            endcase
            // waypoint words
            if (ch == wrlp_pkg::CH_SPACE) begin
               if (word_num_ff != 2'd2) begin
                  word_num_in = word_num_ff + 1'b1;
               end
            end else if (word_num_ff != 2'd2 && !stop_flags_ff[word_num_ff[0]]) begin
               if (ch == wrlp_pkg::CH_MINUS) begin
                  neg_flags_in[word_num_ff[0]] = 1'b1;
               end else if (is_digit) begin
                  if (word_num_ff == 2'd0) begin
                     acc_first_in = word_acc_next;
                  end else begin
                     acc_second_in = word_acc_next;
                  end
               end else begin
                  stop_flags_in[word_num_ff[0]] = 1'b1;
               end
            end
         end
         wrlp_pkg::TOK_EOL: begin
            line_type_in   = '0;
            word_num_in    = '0;
            acc_first_in   = '0;
            acc_second_in  = '0;
            neg_flags_in   = '0;
            stop_flags_in  = '0;
            count_acc_in   = '0;
            count_phase_in = PH_SKIP;
            if (line_type_ff == wrlp_pkg::CH_W) begin
               next_index_in = next_index_ff + 1'b1;
            end else if (line_type_ff == wrlp_pkg::CH_E) begin
               next_index_in = '0;
            end
         end
         default: begin
            line_type_in = line_type_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_type_ff   <= '0;
         word_num_ff    <= '0;
         acc_first_ff   <= '0;
         acc_second_ff  <= '0;
         neg_flags_ff   <= '0;
         stop_flags_ff  <= '0;
         count_acc_ff   <= '0;
         count_phase_ff <= PH_SKIP;
         next_index_ff  <= '0;
      end else if (tok_pop) begin
         line_type_ff   <= line_type_in;
         word_num_ff    <= word_num_in;
         acc_first_ff   <= acc_first_in;
         acc_second_ff  <= acc_second_in;
         neg_flags_ff   <= neg_flags_in;
         stop_flags_ff  <= stop_flags_in;
         count_acc_ff   <= count_acc_in;
         count_phase_ff <= count_phase_in;
         next_index_ff  <= next_index_in;
      end
   end

   // count limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= wrlp_pkg::MAX_COUNT_RESET;
      end else if (csr_wr_en) begin
         max_count_ff <= csr_wr_data;
      end
   end

   // checks
   a_eol_needs_room: assert property (@(posedge clock) disable iff (reset)
      tok_pop && is_eol |-> !rsp_full)
      else $error("line end consumed while result queue full");

   a_eol_clears_line: assert property (@(posedge clock) disable iff (reset)
      tok_pop && is_eol |=> word_num_ff == 2'd0 && count_phase_ff == PH_SKIP &&
                            line_type_ff == 8'd0 && stop_flags_ff == 2'd0)
      else $error("line state not cleared after line end");

   a_end_clears_index: assert property (@(posedge clock) disable iff (reset)
      tok_pop && is_eol && line_type_ff == wrlp_pkg::CH_E |=> next_index_ff == 16'd0)
      else $error("waypoint index not cleared by end line");

   a_waypoint_advances: assert property (@(posedge clock) disable iff (reset)
      tok_pop && is_eol && line_type_ff == wrlp_pkg::CH_W |=>
         next_index_ff == $past(next_index_ff) + 16'd1)
      else $error("waypoint index did not advance");

endmodule
